>>> src/atcp_pkg.sv
// ----------------------------------------------------------------------------
// atcp_pkg: shared types and constants of the text console parser
// Result codes, character codes, the colour table and the bundles between
// the controller and the datapath.
// ----------------------------------------------------------------------------
package atcp_pkg;

	// result kinds
	typedef enum logic [1:0] {
		KIND_WRITE  = 2'd0,
		KIND_SCROLL = 2'd1,
		KIND_CLEAR  = 2'd2,
		KIND_CURSOR = 2'd3
	} kind_t;

	// configuration register indexes
	localparam logic REG_COLUMNS = 1'b0;
	localparam logic REG_ROWS    = 1'b1;

	localparam logic [7:0] COLUMNS_RESET = 8'd80;
	localparam logic [7:0] ROWS_RESET    = 8'd25;

	// character codes
	localparam logic [7:0] CH_BS     = 8'h08;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_ESC    = 8'h1B;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TILDE  = 8'h7E;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_UPPER_J = 8'h4A;
	localparam logic [7:0] CH_LOWER_M = 8'h6D;
	localparam logic [7:0] CH_LOWER_F = 8'h66;

	// colours
	localparam logic [3:0] FG_DEFAULT = 4'h7;
	localparam logic [3:0] BG_DEFAULT = 4'h0;
	localparam logic [7:0] BLANK_ATTR = {BG_DEFAULT, FG_DEFAULT};

	// SGR code ranges
	localparam logic [15:0] SGR_RESET   = 16'd0;
	localparam logic [15:0] SGR_FG_LO   = 16'd30;
	localparam logic [15:0] SGR_FG_HI   = 16'd37;
	localparam logic [15:0] SGR_FGB_LO  = 16'd90;
	localparam logic [15:0] SGR_FGB_HI  = 16'd97;
	localparam logic [15:0] SGR_BG_LO   = 16'd40;
	localparam logic [15:0] SGR_BG_HI   = 16'd47;
	localparam logic [15:0] SGR_BGB_LO  = 16'd100;
	localparam logic [15:0] SGR_BGB_HI  = 16'd107;
	localparam logic [15:0] CLEAR_ALL   = 16'd2;

	localparam logic [15:0] NUM_MAX  = 16'hFFFF;
	localparam logic [15:0] NUM_INIT = 16'd1;

	// ANSI colour number to VGA colour number
	localparam logic [3:0] VGA_OF_ANSI [16] = '{
		4'h0, 4'h4, 4'h2, 4'h6, 4'h1, 4'h5, 4'h3, 4'h7,
		4'h8, 4'hC, 4'hA, 4'hE, 4'h9, 4'hD, 4'hB, 4'hF
	};

	// divider geometry
	localparam int DIV_W   = 17;
	localparam int DIV_CW  = $clog2(DIV_W + 1);

	localparam int RES_DEPTH = 3;
	localparam int RES_IW    = $clog2(RES_DEPTH);

	typedef struct packed {
		kind_t      kind;
		logic [7:0] column;
		logic [7:0] row;
		logic [7:0] glyph;
		logic [7:0] attribute;
	} res_t;

	typedef struct packed {
		logic take;      // latch request, decode character
		logic div_step;  // one divider iteration
		logic finish_a;  // column known, start row division
		logic finish_b;  // row known, cursor result ready
		logic pop;       // result taken by receiver
	} ctrl_cmd_t;

	typedef struct packed {
		logic need_div;  // pending character is a cursor position command
		logic div_done;
		logic res_last;  // current result is the final one of the request
	} ctrl_stat_t;

endpackage

>>> src/atcp_div.sv
// ----------------------------------------------------------------------------
// atcp_div: radix-2 restoring divider
// One quotient bit per step; remainder against an 8-bit divisor.
// ----------------------------------------------------------------------------
module atcp_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        load,
	input  logic                        step,
	input  logic [atcp_pkg::DIV_W-1:0]  dividend,
	input  logic [7:0]                  divisor,
	output logic                        done,
	output logic [7:0]                  rem,
	output logic [atcp_pkg::DIV_W-1:0]  quo
);

	logic [atcp_pkg::DIV_CW-1:0] cnt_q;
	logic [7:0]                  rem_q;
	logic [atcp_pkg::DIV_W-1:0]  quo_q;
	logic [7:0]                  dsr_q;
	logic [8:0]                  part;
	logic                        fits;

	assign part = {rem_q, quo_q[atcp_pkg::DIV_W-1]};
	assign fits = part >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= atcp_pkg::DIV_CW'(atcp_pkg::DIV_W);
		end else if (step && cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (step && cnt_q != '0) begin
			rem_q <= fits ? 8'(part - {1'b0, dsr_q}) : part[7:0];
			quo_q <= {quo_q[atcp_pkg::DIV_W-2:0], fits};
		end
	end

	assign done = (cnt_q == '0);
	assign rem  = rem_q;
	assign quo  = quo_q;

endmodule

>>> src/atcp_dp.sv
// ----------------------------------------------------------------------------
// atcp_dp: parser datapath
// Escape parser, numbers, colours, cursor, geometry and the result queue.
// ----------------------------------------------------------------------------
module atcp_dp (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic                   cfg_index,
	input  logic [7:0]             cfg_data,
	input  logic [7:0]             char_code,
	input  atcp_pkg::ctrl_cmd_t    cmd,
	output atcp_pkg::ctrl_stat_t   stat,
	output atcp_pkg::res_t         res
);

	typedef enum logic [5:0] {
		PS_TEXT  = 6'b000001,
		PS_ESC   = 6'b000010,
		PS_BRACK = 6'b000100,
		PS_NUM1  = 6'b001000,
		PS_SEMI  = 6'b010000,
		PS_NUM2  = 6'b100000
	} ps_t;

	ps_t         ps_q, ps_n;
	logic [15:0] num1_q, num1_n, num2_q, num2_n;
	logic [7:0]  cols_q, rows_q, col_q, row_q, col_n, row_n;
	logic [3:0]  fg_q, fg_n, bg_q, bg_n;

	atcp_pkg::res_t              q_q [atcp_pkg::RES_DEPTH];
	atcp_pkg::res_t              q_n [atcp_pkg::RES_DEPTH];
	logic [atcp_pkg::RES_IW-1:0] cnt_q, cnt_n, idx_q;

	logic        need_div;
	logic        plain, is_dig, printable, scroll, has_first;
	logic [3:0]  dig;
	logic [19:0] p1, p2;
	logic [15:0] push1, push2, sgr_fg, sgr_bg, sgr_fgb, sgr_bgb;
	atcp_pkg::res_t first, cur, scr;

	// divider
	logic                       div_load, div_done;
	logic [atcp_pkg::DIV_W-1:0] div_dvd, div_quo;
	logic [7:0]                 div_dsr, div_rem;
	logic [7:0]                 cfg_v;

	assign is_dig = (char_code >= atcp_pkg::CH_ZERO) && (char_code <= atcp_pkg::CH_NINE);
	assign dig    = char_code[3:0];
	assign printable = ((char_code >= atcp_pkg::CH_SPACE) && (char_code <= atcp_pkg::CH_TILDE))
		|| char_code[7];

	// n * 10 + digit, saturating
	assign p1 = ({4'd0, num1_q} << 3) + ({4'd0, num1_q} << 1) + {16'd0, dig};
	assign p2 = ({4'd0, num2_q} << 3) + ({4'd0, num2_q} << 1) + {16'd0, dig};
	assign push1 = (p1 > {4'd0, atcp_pkg::NUM_MAX}) ? atcp_pkg::NUM_MAX : p1[15:0];
	assign push2 = (p2 > {4'd0, atcp_pkg::NUM_MAX}) ? atcp_pkg::NUM_MAX : p2[15:0];
	assign sgr_fg  = num1_q - atcp_pkg::SGR_FG_LO;
	assign sgr_bg  = num1_q - atcp_pkg::SGR_BG_LO;
	assign sgr_fgb = num1_q - atcp_pkg::SGR_FGB_LO;
	assign sgr_bgb = num1_q - atcp_pkg::SGR_BGB_LO;

	always_comb begin
		ps_n      = ps_q;
		num1_n    = num1_q;
		num2_n    = num2_q;
		fg_n      = fg_q;
		bg_n      = bg_q;
		col_n     = col_q;
		row_n     = row_q;
		plain     = 1'b0;
		need_div  = 1'b0;
		scroll    = 1'b0;
		has_first = 1'b0;
		first     = '{atcp_pkg::KIND_CLEAR, 8'd0, 8'd0, atcp_pkg::CH_SPACE,
			atcp_pkg::BLANK_ATTR};

		unique case (ps_q)
			PS_TEXT: plain = 1'b1;
			PS_ESC, PS_BRACK: begin
				if (is_dig) begin
					num1_n = {12'd0, dig};
					ps_n   = PS_NUM1;
				end else if (ps_q == PS_ESC && char_code == atcp_pkg::CH_LBRACK) begin
					ps_n = PS_BRACK;
				end else begin
					ps_n  = PS_TEXT;
					plain = 1'b1;
				end
			end
			PS_NUM1: begin
				ps_n = PS_TEXT;
				if (is_dig) begin
					num1_n = push1;
					ps_n   = PS_NUM1;
				end else if (char_code == atcp_pkg::CH_UPPER_J) begin
					if (num1_q == atcp_pkg::CLEAR_ALL) begin
						has_first = 1'b1;
						col_n     = '0;
						row_n     = '0;
					end
				end else if (char_code == atcp_pkg::CH_LOWER_M) begin
					if (num1_q == atcp_pkg::SGR_RESET) begin
						fg_n = atcp_pkg::FG_DEFAULT;
						bg_n = atcp_pkg::BG_DEFAULT;
					end else if (num1_q >= atcp_pkg::SGR_FG_LO && num1_q <= atcp_pkg::SGR_FG_HI) begin
						fg_n = atcp_pkg::VGA_OF_ANSI[{1'b0, sgr_fg[2:0]}];
					end else if (num1_q >= atcp_pkg::SGR_FGB_LO
						&& num1_q <= atcp_pkg::SGR_FGB_HI) begin
						// bright colours sit in the upper half of the table
						fg_n = atcp_pkg::VGA_OF_ANSI[{1'b1, sgr_fgb[2:0]}];
					end else if (num1_q >= atcp_pkg::SGR_BG_LO && num1_q <= atcp_pkg::SGR_BG_HI) begin
						bg_n = atcp_pkg::VGA_OF_ANSI[{1'b0, sgr_bg[2:0]}];
					end else if (num1_q >= atcp_pkg::SGR_BGB_LO
						&& num1_q <= atcp_pkg::SGR_BGB_HI) begin
						bg_n = atcp_pkg::VGA_OF_ANSI[{1'b1, sgr_bgb[2:0]}];
					end
				end else if (char_code == atcp_pkg::CH_SEMI) begin
					num2_n = '0;
					ps_n   = PS_SEMI;
				end else begin
					plain = 1'b1;
				end
			end
			PS_SEMI: begin
				if (is_dig) begin
					num2_n = {12'd0, dig};
					ps_n   = PS_NUM2;
				end else begin
					ps_n  = PS_TEXT;
					plain = 1'b1;
				end
			end
			PS_NUM2: begin
				ps_n = PS_TEXT;
				if (is_dig) begin
					num2_n = push2;
					ps_n   = PS_NUM2;
				end else if (char_code == atcp_pkg::CH_LOWER_F) begin
					need_div = 1'b1;
				end else begin
					plain = 1'b1;
				end
			end
			default: ps_n = PS_TEXT;
		endcase

		if (plain) begin
			if (printable) begin
				has_first = 1'b1;
				first = '{atcp_pkg::KIND_WRITE, col_q, row_q, char_code, {bg_q, fg_q}};
				if (col_q == cols_q - 8'd1) begin
					col_n = '0;
					if (row_q == rows_q - 8'd1) scroll = 1'b1;
					else row_n = row_q + 8'd1;
				end else begin
					col_n = col_q + 8'd1;
				end
			end else if (char_code == atcp_pkg::CH_LF || char_code == atcp_pkg::CH_CR) begin
				col_n = '0;
				if (row_q == rows_q - 8'd1) scroll = 1'b1;
				else row_n = row_q + 8'd1;
			end else if (char_code == atcp_pkg::CH_BS) begin
				// at the origin the cursor stays and cell (0,0) is blanked
				if (col_q != '0) begin
					col_n = col_q - 8'd1;
				end else if (row_q != '0) begin
					col_n = cols_q - 8'd1;
					row_n = row_q - 8'd1;
				end
				has_first = 1'b1;
				first = '{atcp_pkg::KIND_WRITE, col_n, row_n, atcp_pkg::CH_SPACE,
					atcp_pkg::BLANK_ATTR};
			end else if (char_code == atcp_pkg::CH_ESC) begin
				ps_n = PS_ESC;
			end
		end

		cur = '{atcp_pkg::KIND_CURSOR, col_n, row_n, 8'd0, 8'd0};
		scr = '{atcp_pkg::KIND_SCROLL, 8'd0, 8'd0, atcp_pkg::CH_SPACE, atcp_pkg::BLANK_ATTR};

		q_n[0] = cur;
		q_n[1] = cur;
		q_n[2] = cur;
		cnt_n  = atcp_pkg::RES_IW'(1);
		if (has_first) begin
			q_n[0] = first;
			if (scroll) begin
				q_n[1] = scr;
				cnt_n  = atcp_pkg::RES_IW'(3);
			end else begin
				cnt_n  = atcp_pkg::RES_IW'(2);
			end
		end else if (scroll) begin
			q_n[0] = scr;
			cnt_n  = atcp_pkg::RES_IW'(2);
		end
	end

	// column = h mod columns; row = (v + h / columns) mod rows
	assign div_load = (cmd.take && need_div) || cmd.finish_a;
	assign div_dvd  = cmd.finish_a ? ({1'b0, num2_q} + {1'b0, div_quo[15:0]})
		: {1'b0, num1_q};
	assign div_dsr  = cmd.finish_a ? rows_q : cols_q;

	atcp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (div_load),
		.step     (cmd.div_step),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.done     (div_done),
		.rem      (div_rem),
		.quo      (div_quo)
	);

	assign cfg_v = (cfg_data == 8'd0) ? 8'd1 : cfg_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ps_q   <= PS_TEXT;
			num1_q <= atcp_pkg::NUM_INIT;
			num2_q <= atcp_pkg::NUM_INIT;
			col_q  <= '0;
			row_q  <= '0;
			fg_q   <= atcp_pkg::FG_DEFAULT;
			bg_q   <= atcp_pkg::BG_DEFAULT;
			cols_q <= atcp_pkg::COLUMNS_RESET;
			rows_q <= atcp_pkg::ROWS_RESET;
			cnt_q  <= atcp_pkg::RES_IW'(1);
			idx_q  <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					atcp_pkg::REG_COLUMNS: cols_q <= cfg_v;
					atcp_pkg::REG_ROWS:    rows_q <= cfg_v;
					default: ;
				endcase
				col_q <= '0;
				row_q <= '0;
			end else if (cmd.take) begin
				ps_q   <= ps_n;
				num1_q <= num1_n;
				num2_q <= num2_n;
				fg_q   <= fg_n;
				bg_q   <= bg_n;
				if (!need_div) begin
					col_q <= col_n;
					row_q <= row_n;
				end
				cnt_q  <= cnt_n;
				idx_q  <= '0;
			end else if (cmd.finish_a) begin
				col_q <= div_rem;
			end else if (cmd.finish_b) begin
				row_q <= div_rem;
			end else if (cmd.pop) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			q_q[0] <= q_n[0];
			q_q[1] <= q_n[1];
			q_q[2] <= q_n[2];
		end else if (cmd.finish_b) begin
			q_q[0] <= '{atcp_pkg::KIND_CURSOR, col_q, div_rem, 8'd0, 8'd0};
		end
	end

	always_comb begin
		case (idx_q)
			2'd0:    res = q_q[0];
			2'd1:    res = q_q[1];
			default: res = q_q[2];
		endcase
	end

	assign stat.need_div = need_div;
	assign stat.div_done = div_done;
	assign stat.res_last = (idx_q == cnt_q - 1'b1);

endmodule

>>> src/atcp_ctrl.sv
// ----------------------------------------------------------------------------
// atcp_ctrl: request sequencer
// Takes a character, runs the two cursor divisions when needed, then
// hands out the queued results.
// ----------------------------------------------------------------------------
module atcp_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  logic                   out_ready,
	input  atcp_pkg::ctrl_stat_t   stat,
	output atcp_pkg::ctrl_cmd_t    cmd
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_DIV_A = 4'b0010,
		ST_DIV_B = 4'b0100,
		ST_OUT   = 4'b1000
	} state_t;

	state_t state_q, state_n;

	always_comb begin
		state_n   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					state_n  = stat.need_div ? ST_DIV_A : ST_OUT;
				end
			end
			ST_DIV_A: begin
				if (stat.div_done) begin
					cmd.finish_a = 1'b1;
					state_n      = ST_DIV_B;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			ST_DIV_B: begin
				if (stat.div_done) begin
					cmd.finish_b = 1'b1;
					state_n      = ST_OUT;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					cmd.pop = 1'b1;
					if (stat.res_last) state_n = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

endmodule

>>> src/ansi_text_console_parser.sv
// ----------------------------------------------------------------------------
// ansi_text_console_parser: escape-sequence text console front end
// Turns a character stream into cell write, scroll, clear and cursor
// requests for a character screen.
// ----------------------------------------------------------------------------
// Usage:
//  - s_axis carries one character per request in tdata[7:0].
//  - m_axis returns 1 to 3 results per character, kind in tuser; tlast marks
//    the final one, which is always the cursor placement.
//  - cfg_we/cfg_index/cfg_data write columns (0) or rows (1); a zero stores
//    one and the cursor homes to (0,0). Write only while idle.
// Timing:
//  - A character is taken in the idle state, then its results leave at one per
//    cycle while the receiver holds m_axis_tready high.
//  - ESC h;v f runs the shared radix-2 divider twice (column mod, then row
//    mod) before the cursor result.
//  - One character is in flight at a time; s_axis_tready is low until the
//    last result is taken. A stalled receiver holds the result steady.
// Reset: geometry 80 x 25, cursor at origin, colours 7 on 0, text mode.
// ----------------------------------------------------------------------------
module ansi_text_console_parser (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	// character input
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
	// result output
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // column, row, glyph, attribute
	output logic [1:0]  m_axis_tuser,   // [1:0] kind
	output logic        m_axis_tlast
);

	atcp_pkg::ctrl_cmd_t  cmd;
	atcp_pkg::ctrl_stat_t stat;
	atcp_pkg::res_t       res;

	// sequencer: owns the handshakes
	atcp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// parser, cursor and result queue
	atcp_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.char_code (s_axis_tdata),
		.cmd       (cmd),
		.stat      (stat),
		.res       (res)
	);

	// pack lowest field first
	assign m_axis_tdata = {res.attribute, res.glyph, res.row, res.column};
	assign m_axis_tuser = res.kind;
	assign m_axis_tlast = stat.res_last;

	// no overlap between taking a character and handing out results
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid))
		else $error("input and output active together");

	// a request is taken only once
	a_take_once: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input ready right after a take");

	// the final result is the cursor placement, and only it
	a_last_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tlast == (res.kind == atcp_pkg::KIND_CURSOR)))
		else $error("tlast does not match cursor result");

	// after the final result the block is ready again
	a_back_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready)
		else $error("not ready after final result");

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the text console parser
// Sends character streams (directed corner cases, then random text, control
// bytes and well-formed or broken escape sequences) across several screen
// geometries. The expected cell, scroll, clear and cursor results are
// computed locally for each request taken, and every returned result is
// compared field by field in order.
// ----------------------------------------------------------------------------
module testbench;
	import atcp_pkg::*;

	localparam int          HOLD_CYCLES = 300;  // long receiver hold-off
	localparam int          TAIL_CYCLES = 60;   // > divider latency plus results
	localparam int unsigned MAX_PRINTS  = 100;

	// parser states of the local screen predictor
	typedef enum logic [2:0] {
		PS_TEXT    = 3'd0,
		PS_ESC     = 3'd1,
		PS_NUM1    = 3'd2,
		PS_SEMI    = 3'd3,
		PS_NUM2    = 3'd4,
		PS_BRACKET = 3'd5
	} parse_t;

	typedef struct {
		kind_t      kind;
		logic [7:0] column;
		logic [7:0] row;
		logic [7:0] glyph;
		logic [7:0] attribute;
		logic       last;
	} screen_op_t;

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// block ports, all known from time zero
	logic        cfg_we        = 1'b0;
	logic        cfg_index     = REG_COLUMNS;
	logic [7:0]  cfg_data      = 8'd0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = 8'd0;  // [7:0] char_code
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;          // [7:0] column, [15:8] row,
	                                    // [23:16] glyph, [31:24] attribute
	logic [1:0]  m_axis_tuser;          // [1:0] kind
	logic        m_axis_tlast;

	// stimulus and expectations
	logic [7:0]  char_q[$];        // characters waiting for the driver
	logic [7:0]  seq_buf[$];       // one sequence under construction
	screen_op_t  screen_ops_due[$];
	int unsigned error_count = 0;

	// sender pacing
	logic        steady_send = 1'b0;
	int unsigned gap_left    = 0;
	int unsigned burst_left  = 0;

	// receiver pacing
	logic [9:0]  stall_tick  = '0;
	logic        hold_req    = 1'b0;
	logic        hold_taken  = 1'b0;
	int unsigned hold_left   = 0;

	// predictor state
	int unsigned scr_cols;
	int unsigned scr_rows;
	int unsigned cur_pos;
	int unsigned num1;
	int unsigned num2;
	logic [3:0]  fg;
	logic [3:0]  bg;
	parse_t      pstate;

	ansi_text_console_parser dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #1 clk = ~clk;

	// ------------------------------------------------------------------
	// screen predictor
	// ------------------------------------------------------------------
	task automatic emit_op(input kind_t k, input int unsigned col, input int unsigned row_n,
			input logic [7:0] g, input logic [7:0] a, input logic l);
		screen_op_t op;
		op.kind      = k;
		op.column    = col[7:0];
		op.row       = row_n[7:0];
		op.glyph     = g;
		op.attribute = a;
		op.last      = l;
		screen_ops_due.push_back(op);
	endtask

	function automatic int unsigned add_digit(input int unsigned n, input logic [7:0] c);
		int unsigned v;
		v = n * 10 + (c - CH_ZERO);
		return (v > NUM_MAX) ? NUM_MAX : v;
	endfunction

	function automatic logic digit_char(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	task automatic apply_sgr(input int unsigned code);
		if (code == SGR_RESET) begin
			fg = FG_DEFAULT;
			bg = BG_DEFAULT;
		end else if (code >= SGR_FG_LO && code <= SGR_FG_HI) begin
			fg = VGA_OF_ANSI[code - SGR_FG_LO];
		end else if (code >= SGR_FGB_LO && code <= SGR_FGB_HI) begin
			fg = VGA_OF_ANSI[8 + code - SGR_FGB_LO];
		end else if (code >= SGR_BG_LO && code <= SGR_BG_HI) begin
			bg = VGA_OF_ANSI[code - SGR_BG_LO];
		end else if (code >= SGR_BGB_LO && code <= SGR_BGB_HI) begin
			bg = VGA_OF_ANSI[8 + code - SGR_BGB_LO];
		end
		// anything else: unknown code, colours unchanged
	endtask

	// character outside an escape sequence
	task automatic text_char(input logic [7:0] c);
		if ((c >= CH_SPACE && c <= CH_TILDE) || c[7]) begin
			emit_op(KIND_WRITE, cur_pos % scr_cols, cur_pos / scr_cols, c, {bg, fg}, 1'b0);
			cur_pos++;
		end else if (c == CH_LF || c == CH_CR) begin
			cur_pos = (cur_pos / scr_cols + 1) * scr_cols;
		end else if (c == CH_BS) begin
			// clamps at the origin, still blanks cell (0,0)
			if (cur_pos > 0)
				cur_pos--;
			emit_op(KIND_WRITE, cur_pos % scr_cols, cur_pos / scr_cols, CH_SPACE, BLANK_ATTR,
				1'b0);
		end else if (c == CH_ESC) begin
			pstate = PS_ESC;
		end
		// other control bytes and DEL: cursor report only
	endtask

	task automatic predict_screen_ops(input logic [7:0] c);
		logic again;
		again = 1'b0;
		if (pstate == PS_TEXT) begin
			text_char(c);
		end else begin
			case (pstate)
				PS_ESC, PS_BRACKET: begin
					if (digit_char(c)) begin
						num1   = c - CH_ZERO;
						pstate = PS_NUM1;
					end else if (pstate == PS_ESC && c == CH_LBRACK) begin
						pstate = PS_BRACKET;
					end else begin
						pstate = PS_TEXT;
						again  = 1'b1;
					end
				end
				PS_NUM1: begin
					if (digit_char(c)) begin
						num1 = add_digit(num1, c);
					end else if (c == CH_UPPER_J) begin
						if (num1 == CLEAR_ALL) begin
							emit_op(KIND_CLEAR, 0, 0, CH_SPACE, BLANK_ATTR, 1'b0);
							cur_pos = 0;
						end
						pstate = PS_TEXT;
					end else if (c == CH_LOWER_M) begin
						apply_sgr(num1);
						pstate = PS_TEXT;
					end else if (c == CH_SEMI) begin
						num2   = 0;
						pstate = PS_SEMI;
					end else begin
						pstate = PS_TEXT;
						again  = 1'b1;
					end
				end
				PS_SEMI: begin
					if (digit_char(c)) begin
						num2   = c - CH_ZERO;
						pstate = PS_NUM2;
					end else begin
						pstate = PS_TEXT;
						again  = 1'b1;
					end
				end
				PS_NUM2: begin
					if (digit_char(c)) begin
						num2 = add_digit(num2, c);
					end else if (c == CH_LOWER_F) begin
						cur_pos = (num2 * scr_cols + num1) % (scr_cols * scr_rows);
						pstate  = PS_TEXT;
					end else begin
						pstate = PS_TEXT;
						again  = 1'b1;
					end
				end
				default: pstate = PS_TEXT;
			endcase
			// a byte that breaks the sequence is then taken as plain text
			if (again)
				text_char(c);
		end
		if (cur_pos >= scr_cols * scr_rows) begin
			emit_op(KIND_SCROLL, 0, 0, CH_SPACE, BLANK_ATTR, 1'b0);
			cur_pos -= scr_cols;
		end
		emit_op(KIND_CURSOR, cur_pos % scr_cols, cur_pos / scr_cols, 8'd0, 8'd0, 1'b1);
	endtask

	// ------------------------------------------------------------------
	// checking
	// ------------------------------------------------------------------
	task automatic report_mismatch(input string msg);
		error_count++;
		if (error_count <= MAX_PRINTS)
			$display("[%0t] MISMATCH %s", $time, msg);
	endtask

	task automatic check_screen_op(input logic [1:0] kind_bits, input logic [31:0] data,
			input logic last);
		screen_op_t want;
		if (screen_ops_due.size() == 0) begin
			report_mismatch($sformatf("result with none expected: tuser=%h tdata=%h tlast=%b",
				kind_bits, data, last));
			return;
		end
		want = screen_ops_due.pop_front();
		if (kind_bits !== want.kind || data[7:0] !== want.column ||
				data[15:8] !== want.row || data[23:16] !== want.glyph ||
				data[31:24] !== want.attribute || last !== want.last)
			report_mismatch($sformatf(
				"got kind=%0d col=%0d row=%0d glyph=%h attr=%h last=%b, want %0d %0d %0d %h %h %b",
				kind_bits, data[7:0], data[15:8], data[23:16], data[31:24], last,
				want.kind, want.column, want.row, want.glyph, want.attribute, want.last));
	endtask

	// ------------------------------------------------------------------
	// driver: bursts with random gaps, or back to back when steady_send
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				predict_screen_ops(s_axis_tdata);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (gap_left > 0 || char_q.size() == 0) begin
					s_axis_tvalid <= 1'b0;
					if (gap_left > 0)
						gap_left--;
				end else begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= char_q.pop_front();
					if (burst_left > 0) begin
						burst_left--;
					end else if (!steady_send) begin
						burst_left = $urandom_range(0, 10);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// monitor: checks taken results and paces tready
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				check_screen_op(m_axis_tuser, m_axis_tdata, m_axis_tlast);
			stall_tick <= stall_tick + 10'd1;
			if (hold_left != 0) begin
				m_axis_tready <= 1'b0;
			end else begin
				// four stretches: always ready, coin flip, mostly ready, square wave
				case (stall_tick[9:8])
					2'd0:    m_axis_tready <= 1'b1;
					2'd1:    m_axis_tready <= 1'($urandom_range(0, 1));
					2'd2:    m_axis_tready <= ($urandom_range(0, 7) != 0);
					default: m_axis_tready <= stall_tick[3];
				endcase
			end
		end
	end

	// one long hold-off so the parser backs up and stalls its input
	always @(posedge clk) begin
		if (hold_req && !hold_taken) begin
			hold_taken <= 1'b1;
			hold_left  <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	function automatic logic [7:0] random_glyph();
		if ($urandom_range(0, 3) == 0)
			return 8'($urandom_range(8'h80, 8'hFF));
		return 8'($urandom_range(CH_SPACE, CH_TILDE));
	endfunction

	function automatic int unsigned pick_param();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 9);
			1: return CLEAR_ALL;
			2: begin
				case ($urandom_range(0, 4))
					0:       return SGR_RESET;
					1:       return SGR_FG_LO + $urandom_range(0, 7);
					2:       return SGR_BG_LO + $urandom_range(0, 7);
					3:       return SGR_FGB_LO + $urandom_range(0, 7);
					default: return SGR_BGB_LO + $urandom_range(0, 7);
				endcase
			end
			3: return $urandom_range(0, 300);
			4: return $urandom_range(65000, 4000000);  // saturates above 65535
			default: return $urandom_range(0, 999);
		endcase
	endfunction

	task automatic append_number(input int unsigned n);
		logic [7:0] digs[$];
		int unsigned v;
		v = n;
		do begin
			digs.push_front(8'(CH_ZERO + v % 10));
			v = v / 10;
		end while (v != 0);
		foreach (digs[i])
			seq_buf.push_back(digs[i]);
	endtask

	// random text, control bytes and escape sequences, some of them broken
	task automatic queue_random_chars(input int unsigned budget);
		int unsigned added;
		int unsigned pick;
		int unsigned cut;
		added = 0;
		while (added < budget) begin
			seq_buf.delete();
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				repeat ($urandom_range(1, 6))
					seq_buf.push_back(random_glyph());
			end else if (pick < 45) begin
				case ($urandom_range(0, 4))
					0:       seq_buf.push_back(CH_LF);
					1:       seq_buf.push_back(CH_CR);
					2:       seq_buf.push_back(CH_BS);
					3:       seq_buf.push_back(8'($urandom_range(0, 31)));
					default: seq_buf.push_back(8'h7F);  // DEL
				endcase
			end else begin
				seq_buf.push_back(CH_ESC);
				if ($urandom_range(0, 1))
					seq_buf.push_back(CH_LBRACK);
				case ($urandom_range(0, 2))
					0: begin
						append_number(pick_param());
						seq_buf.push_back(CH_UPPER_J);
					end
					1: begin
						append_number(pick_param());
						seq_buf.push_back(CH_LOWER_M);
					end
					default: begin
						append_number(pick_param());
						seq_buf.push_back(CH_SEMI);
						append_number(pick_param());
						seq_buf.push_back(CH_LOWER_F);
					end
				endcase
				// broken sequence: cut short, then any byte
				if ($urandom_range(0, 6) == 0) begin
					cut     = $urandom_range(1, seq_buf.size() - 1);
					seq_buf = seq_buf[0:cut-1];
					seq_buf.push_back(8'($urandom_range(0, 255)));
				end
			end
			foreach (seq_buf[i])
				char_q.push_back(seq_buf[i]);
			added += seq_buf.size();
		end
	endtask

	// sampled on the falling edge, after the driver and monitor have settled
	task automatic wait_idle();
		do
			@(negedge clk);
		while (char_q.size() != 0 || s_axis_tvalid || screen_ops_due.size() != 0);
	endtask

	// register write, only while nothing is in flight
	task automatic write_reg(input logic idx, input logic [7:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		if (idx == REG_COLUMNS)
			scr_cols = (val == 8'd0) ? 1 : val;
		else
			scr_rows = (val == 8'd0) ? 1 : val;
		cur_pos = 0;  // geometry change homes the cursor
	endtask

	task automatic set_geometry(input logic [7:0] cols, input logic [7:0] rws);
		wait_idle();
		write_reg(REG_COLUMNS, cols);
		write_reg(REG_ROWS, rws);
	endtask

	task automatic queue_bytes(input logic [7:0] bytes[]);
		foreach (bytes[i])
			char_q.push_back(bytes[i]);
	endtask

	// ------------------------------------------------------------------
	// sequence of phases
	// ------------------------------------------------------------------
	initial begin
		scr_cols = COLUMNS_RESET;
		scr_rows = ROWS_RESET;
		cur_pos  = 0;
		num1     = NUM_INIT;
		num2     = NUM_INIT;
		fg       = FG_DEFAULT;
		bg       = BG_DEFAULT;
		pstate   = PS_TEXT;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset geometry 80 x 25: directed corner cases
		queue_bytes('{
			CH_BS,                                   // backspace at origin
			8'h41, 8'hFF, 8'h00,                     // 'A', top extended, ignored control
			CH_ESC, CH_LBRACK, CH_ZERO + 8'd2, CH_UPPER_J,   // clear screen
			CH_ESC, CH_ZERO + 8'd3, CH_ZERO + 8'd1, CH_LOWER_M,  // red foreground
			8'h80,                                   // lowest extended, coloured
			CH_ESC, CH_NINE, CH_NINE, CH_NINE, CH_NINE, CH_NINE, // column saturates
			CH_SEMI, CH_ZERO + 8'd2, CH_LOWER_F,
			CH_ESC, CH_ZERO + 8'd5, CH_UPPER_J,      // clear with another number
			CH_ESC, 8'h5A                            // 'Z' breaks the sequence
		});

		// zero geometry stores one: every write and newline scrolls
		set_geometry(8'd0, 8'd0);
		queue_bytes('{8'h41, CH_LF});
		queue_random_chars(20);

		// largest screen, sender back to back while the receiver holds off
		set_geometry(8'd255, 8'd255);
		steady_send <= 1'b1;
		hold_req    <= 1'b1;
		queue_random_chars(60);

		set_geometry(8'd7, 8'd3);
		steady_send <= 1'b0;
		queue_random_chars(60);

		set_geometry(8'd1, 8'd200);
		queue_random_chars(60);

		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		@(negedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// watchdog
	initial begin
		#500000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
